FILE: hw/rtl/kprt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kprt_pkg
// Types and constants shared by the key press/release tracker modules.
// ----------------------------------------------------------------------------
package kprt_pkg;

   localparam int CODE_W        = 7;
   localparam int SLOT_W        = 5;
   localparam int SLOTS_PER_REG = 9;
   localparam int CSR_REG_W     = 63;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_ADDR_W    = 4;

   localparam logic [7:0] CODE_MASK = 8'h7f;
   localparam logic [7:0] BREAK_BIT = 8'h80;

   typedef enum logic [1:0] {
      OP_SCANCODE    = 2'd0,
      OP_PROCESS     = 2'd1,
      OP_FORCE_WAIT  = 2'd2,
      OP_FORCE_EMPTY = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KS_EMPTY   = 2'd0,
      KS_WAIT    = 2'd1,
      KS_RELEASE = 2'd2,
      KS_PRESS   = 2'd3
   } key_state_type;

   typedef enum logic [1:0] {
      EV_NONE     = 2'd0,
      EV_PRESSED  = 2'd1,
      EV_RELEASED = 2'd2
   } ev_kind_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_SCANCODE,
      CMD_FORCE_WAIT,
      CMD_FORCE_EMPTY,
      CMD_START,
      CMD_STEP
   } cmd_kind_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_EMIT
   } fsm_type;

   localparam logic CSR_REG_CODES_LO = 1'b0;
   localparam logic CSR_REG_CODES_HI = 1'b1;

   typedef struct packed {
      cmd_kind_type        kind;
      logic                brk;
      logic [CODE_W-1:0]   code;
      logic [SLOT_W-1:0]   slot;
   } cell_cmd_type;

   typedef struct packed {
      ev_kind_type         kind;
      logic [SLOT_W-1:0]   slot;
      logic                last;
   } evt_type;

   function automatic key_state_type state_after_scan(key_state_type s);
      key_state_type r;
      case (s)
         KS_PRESS:   r = KS_WAIT;
         KS_RELEASE: r = KS_EMPTY;
         default:    r = s;
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/kprt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kprt_cell
// One key slot: holds its press/release state and the scan token, which is
// handed to the next cell on every scan step.
// ----------------------------------------------------------------------------
module kprt_cell
   import kprt_pkg::*;
#(
   parameter int SLOT_ID = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  cell_cmd_type        cmd,
   input  logic [CODE_W-1:0]   code,
   input  logic                tok_in,
   input  logic                later_in,
   output logic                tok_out,
   output logic                later_out,
   output key_state_type       state,
   output evt_type             ev
);

   localparam logic [SLOT_W-1:0] MY_SLOT  = SLOT_W'(SLOT_ID);
   localparam logic              IS_FIRST = (SLOT_ID == 0);

   key_state_type state_ff, state_in;
   logic          tok_ff, tok_in_nx;
   logic          pending;

   assign pending = (state_ff == KS_PRESS) || (state_ff == KS_RELEASE);

   always_comb begin
      state_in  = state_ff;
      tok_in_nx = tok_ff;
      case (cmd.kind)
         CMD_SCANCODE: begin
            if (cmd.code == code) begin
               if (cmd.brk) begin
                  state_in = (state_ff == KS_PRESS || state_ff == KS_WAIT) ?
                             KS_RELEASE : KS_EMPTY;
               end else begin
                  state_in = (state_ff == KS_EMPTY || state_ff == KS_RELEASE) ?
                             KS_PRESS : KS_WAIT;
               end
            end
         end
         CMD_FORCE_WAIT: begin
            if (cmd.slot == MY_SLOT) state_in = KS_WAIT;
         end
         CMD_FORCE_EMPTY: begin
            if (cmd.slot == MY_SLOT) state_in = KS_EMPTY;
         end
         CMD_START: begin
            tok_in_nx = IS_FIRST;
         end
         CMD_STEP: begin
            if (tok_ff) state_in = state_after_scan(state_ff);
            tok_in_nx = tok_in;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= KS_EMPTY;
         tok_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         tok_ff   <= tok_in_nx;
      end
   end

   assign tok_out   = tok_ff;
   assign later_out = later_in | pending;
   assign state     = state_ff;

   always_comb begin
      ev = '0;
      if (tok_ff && pending) begin
         ev.kind = (state_ff == KS_PRESS) ? EV_PRESSED : EV_RELEASED;
         ev.slot = MY_SLOT;
         ev.last = ~later_in;
      end
   end

endmodule

FILE: hw/rtl/key_press_release_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_press_release_tracker_top
// Press/release tracking for a row of watched key slots.
// ----------------------------------------------------------------------------
// Requests enter on req_* (valid/ready) and results leave on rsp_* (valid/
// ready); key codes for the slots are written over the csr_* APB port, two
// 64-bit registers at byte addresses 0 and 8.
// Scancode and force requests give one result: the slot row updates at the
// accept edge and the result is loaded in the EMIT state once the result
// register is free. A process request walks a token along the slot chain,
// one slot per cycle unless a full result register holds it, and loads one
// result per press or release event; it ends at the last slot with an event.
// A process request with nothing pending gives a single no-event result.
// Every result reports the key_index slot's state as it stands after the
// whole request.
// The result register holds a result until rsp_ready; while it is full the
// scan waits at the next event slot. A new request is taken as soon as the
// previous request's last result is in the result register.
// Reset empties all slots, zeroes the codes and clears the result valid flag.
// ----------------------------------------------------------------------------
module key_press_release_tracker_top
   import kprt_pkg::*;
#(
   parameter int NUM_KEYS = 18
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_operation,
   input  logic [7:0]              req_scancode,
   input  logic [4:0]              req_key_index,

   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_event_kind,
   output logic [4:0]              rsp_event_slot,
   output logic                    rsp_any_found,
   output logic [1:0]              rsp_slot_state,
   output logic                    rsp_last,

   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   // CSR
   logic [CSR_REG_W-1:0] codes_lo_ff, codes_hi_ff;
   logic                 csr_wr;
   logic                 csr_sel;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_sel    = csr_paddr[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_lo_ff <= '0;
         codes_hi_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_sel)
            CSR_REG_CODES_LO: codes_lo_ff <= csr_pwdata[CSR_REG_W-1:0];
            CSR_REG_CODES_HI: codes_hi_ff <= csr_pwdata[CSR_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         CSR_REG_CODES_LO: csr_prdata = {1'b0, codes_lo_ff};
         CSR_REG_CODES_HI: csr_prdata = {1'b0, codes_hi_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // Slot chain
   cell_cmd_type  cmd;
   logic          tok     [NUM_KEYS];
   logic          later   [NUM_KEYS];
   key_state_type cstate  [NUM_KEYS];
   evt_type       cell_ev [NUM_KEYS];

   for (genvar g = 0; g < NUM_KEYS; g++) begin : g_cell
      logic [CODE_W-1:0] code;
      logic              tin;
      logic              lin;

      if (g < SLOTS_PER_REG) begin : g_lo
         assign code = codes_lo_ff[CODE_W*g +: CODE_W];
      end else begin : g_hi
         assign code = codes_hi_ff[CODE_W*(g-SLOTS_PER_REG) +: CODE_W];
      end

      if (g == 0) begin : g_tfirst
         assign tin = 1'b0;
      end else begin : g_tnext
         assign tin = tok[g-1];
      end

      if (g == NUM_KEYS-1) begin : g_llast
         assign lin = 1'b0;
      end else begin : g_lnext
         assign lin = later[g+1];
      end

      kprt_cell #(.SLOT_ID(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .code      (code),
         .tok_in    (tin),
         .later_in  (lin),
         .tok_out   (tok[g]),
         .later_out (later[g]),
         .state     (cstate[g]),
         .ev        (cell_ev[g])
      );
   end

   logic [$bits(evt_type)-1:0] ev_acc;
   evt_type                    ev_sel;
   logic [NUM_KEYS-1:0]        tok_vec;
   logic                       any_pend;
   logic                       tok_pend;

   always_comb begin
      ev_acc = '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
         ev_acc  = ev_acc | cell_ev[i];
         tok_vec[i] = tok[i];
      end
   end

   assign ev_sel   = evt_type'(ev_acc);
   assign any_pend = later[0];
   assign tok_pend = (ev_sel.kind != EV_NONE);

   // Control
   fsm_type       state_ff, state_in;
   logic [4:0]    kidx_ff;
   key_state_type rpt_ff;
   key_state_type req_sel_state, kidx_sel_state;
   logic          accept;
   logic          out_free;
   logic          step;
   logic          load_emit, load_event;
   op_type        op;

   logic          rsp_valid_ff;
   ev_kind_type   rsp_kind_ff;
   logic [4:0]    rsp_slot_ff;
   logic          rsp_found_ff;
   key_state_type rsp_state_ff;
   logic          rsp_last_ff;

   assign op       = op_type'(req_operation);
   assign out_free = ~rsp_valid_ff | rsp_ready;
   assign accept   = req_valid & req_ready;
   assign step     = (state_ff == FSM_SCAN) & (~tok_pend | out_free);

   always_comb begin
      req_sel_state  = KS_EMPTY;
      kidx_sel_state = KS_EMPTY;
      for (int i = 0; i < NUM_KEYS; i++) begin
         if (req_key_index == SLOT_W'(i)) req_sel_state  = cstate[i];
         if (kidx_ff == SLOT_W'(i))       kidx_sel_state = cstate[i];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               state_in = (op == OP_PROCESS && any_pend) ? FSM_SCAN : FSM_EMIT;
            end
         end
         FSM_SCAN: begin
            if (step && tok_pend && ev_sel.last) state_in = FSM_IDLE;
         end
         FSM_EMIT: begin
            if (out_free) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      load_emit  = 1'b0;
      load_event = 1'b0;
      cmd        = '0;
      cmd.kind   = CMD_NONE;
      cmd.brk    = (req_scancode & BREAK_BIT) != 8'h00;
      cmd.code   = CODE_W'(req_scancode & CODE_MASK);
      cmd.slot   = req_key_index;
      unique case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (op)
                  OP_SCANCODE:    cmd.kind = CMD_SCANCODE;
                  OP_PROCESS:     cmd.kind = any_pend ? CMD_START : CMD_NONE;
                  OP_FORCE_WAIT:  cmd.kind = CMD_FORCE_WAIT;
                  OP_FORCE_EMPTY: cmd.kind = CMD_FORCE_EMPTY;
                  default:        cmd.kind = CMD_NONE;
               endcase
            end
         end
         FSM_SCAN: begin
            if (step) cmd.kind = CMD_STEP;
            load_event = step & tok_pend;
         end
         FSM_EMIT: begin
            load_emit = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kidx_ff <= req_key_index;
         rpt_ff  <= state_after_scan(req_sel_state);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_emit || load_event) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_emit) begin
         rsp_kind_ff  <= EV_NONE;
         rsp_slot_ff  <= '0;
         rsp_found_ff <= 1'b0;
         rsp_state_ff <= kidx_sel_state;
         rsp_last_ff  <= 1'b1;
      end else if (load_event) begin
         rsp_kind_ff  <= ev_sel.kind;
         rsp_slot_ff  <= ev_sel.slot;
         rsp_found_ff <= 1'b1;
         rsp_state_ff <= rpt_ff;
         rsp_last_ff  <= ev_sel.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign rsp_event_slot = rsp_slot_ff;
   assign rsp_any_found  = rsp_found_ff;
   assign rsp_slot_state = rsp_state_ff;
   assign rsp_last       = rsp_last_ff;

   // Assertions
   a_tok_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("more than one scan token in the slot chain");

   a_scan_has_tok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_SCAN) |-> (tok_vec != '0))
      else $error("scan running without a token");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (load_event && ev_sel.last) |=> (state_ff == FSM_IDLE))
      else $error("scan did not end after its last event");

   a_event_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_kind != EV_NONE) |-> rsp_any_found)
      else $error("event result without any_found");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !(load_emit || load_event))
      else $error("result register overwritten while stalled");

endmodule
